// ===== hdl/rpn_pkg.sv =====
// ----------------------------------------------------------------------------
// RPN stack calculator package
// Shared widths, token codes and the request and response types of the
// shared arithmetic unit.
// ----------------------------------------------------------------------------
package rpn_pkg;

    // Default number of stack entries.
    localparam int RPN_STACK_DEPTH = 128;

    // Fixed field widths of the token and result beats.
    localparam int WORD_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int OP_W    = 3;
    localparam int DEPTH_W = 8;

    // Restoring divider: a 48-bit dividend, one quotient bit per step.
    localparam int DIV_N_W   = WORD_W + FRAC_W;
    localparam int DIV_STEPS = DIV_N_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [WORD_W-1:0] Q_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] Q_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    // Token codes. The one code left over is ignored by the block.
    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 3'd0,
        OP_ADD    = 3'd1,
        OP_SUB    = 3'd2,
        OP_MUL    = 3'd3,
        OP_DIV    = 3'd4,
        OP_MOD    = 3'd5,
        OP_FINISH = 3'd6
    } t_op;

    typedef struct packed {
        logic                     start;
        t_op                      op;
        logic signed [WORD_W-1:0] a;
        logic signed [WORD_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic                     done;
        logic signed [WORD_W-1:0] result;
        logic                     sat;
    } t_alu_rsp;

endpackage

// ===== hdl/rpn_cmd_if.sv =====
// ----------------------------------------------------------------------------
// RPN token channel
// Carries one token beat: an operation code and a Q15.16 value.
// ----------------------------------------------------------------------------
interface rpn_cmd_if import rpn_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic signed [WORD_W-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);

endinterface

// ===== hdl/rpn_res_if.sv =====
// ----------------------------------------------------------------------------
// RPN result channel
// Carries one result beat: the top of stack, the depth and the status flags.
// ----------------------------------------------------------------------------
interface rpn_res_if import rpn_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] top_value;
    logic [DEPTH_W-1:0]       stack_depth;
    logic                     final_res;
    logic                     stack_full;
    logic                     stack_empty;
    logic                     zero_divisor;
    logic                     saturated;
    logic                     bad_expression;

    modport source (
        output valid, output top_value, output stack_depth, output final_res,
        output stack_full, output stack_empty, output zero_divisor,
        output saturated, output bad_expression, input ready
    );
    modport sink (
        input valid, input top_value, input stack_depth, input final_res,
        input stack_full, input stack_empty, input zero_divisor,
        input saturated, input bad_expression, output ready
    );

endinterface

// ===== hdl/rpn_stack_calculator.sv =====
// ----------------------------------------------------------------------------
// RPN stack calculator
// Evaluates reverse Polish tokens on a Q15.16 value stack, one token at a time.
// ----------------------------------------------------------------------------
// Push, finish and the unused code go from acceptance straight to S_LOAD;
// the arithmetic tokens pass S_OPER and S_ALU first, but a divide or modulo
// that finds a zero divisor skips S_ALU. The next token is taken in the cycle
// after the result loads; divide and modulo are the slowest tokens, set by
// the 48 one-bit divider steps. Reset (synchronous, active low) empties
// the stack and drops any pending beat; stack contents are not cleared.
module rpn_stack_calculator import rpn_pkg::*; #(
    parameter int STACK_DEPTH = RPN_STACK_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rpn_cmd_if.sink    i_cmd,
    rpn_res_if.source  o_res
);

    // The pointer must hold the full depth, the index only the entries.
    localparam int SP_W  = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = $clog2(STACK_DEPTH);

    // The sequencer: S_OPER has the second operand in r_rd, S_ALU waits on the
    // shared unit, and S_LOAD hands the finished result to the output register.
    typedef enum logic [1:0] {S_IDLE, S_OPER, S_ALU, S_LOAD} t_state;

    t_state                   r_state;
    t_op                      r_op;
    logic [SP_W-1:0]          r_sp;
    // Cached copy of the top entry; meaningful only while the stack is not empty.
    logic signed [WORD_W-1:0] r_top;
    logic signed [WORD_W-1:0] r_rd;
    logic                     r_fin;
    logic                     r_full;
    logic                     r_empty;
    logic                     r_zdiv;
    logic                     r_sat;
    logic                     r_bad;

    // Output register, so a waiting result beat does not block the next token.
    logic                     r_out_valid;
    logic signed [WORD_W-1:0] r_o_top;
    logic [DEPTH_W-1:0]       r_o_depth;
    logic                     r_o_fin;
    logic                     r_o_full;
    logic                     r_o_empty;
    logic                     r_o_zdiv;
    logic                     r_o_sat;
    logic                     r_o_bad;

    logic [WORD_W-1:0]        r_stack [STACK_DEPTH];

    t_alu_req                 alu_req;
    t_alu_rsp                 alu_rsp;

    logic                     cmd_acc;
    t_op                      cmd_op;
    logic                     sp_full;
    logic                     sp_ge1;
    logic                     sp_ge2;
    logic signed [WORD_W-1:0] b_val;
    logic                     b_int_zero;
    logic                     div_zero;
    logic                     out_free;
    logic                     mem_we;
    logic [IDX_W-1:0]         wr_idx;
    logic [IDX_W-1:0]         rd_idx;
    logic [WORD_W-1:0]        wr_data;

    assign i_cmd.ready = (r_state == S_IDLE);
    assign cmd_acc     = i_cmd.valid && i_cmd.ready;
    assign cmd_op      = t_op'(i_cmd.op);

    assign sp_full = (r_sp == SP_W'(STACK_DEPTH));
    assign sp_ge1  = (r_sp != '0);
    assign sp_ge2  = (r_sp >= SP_W'(2));

    // The first pop is the right operand; an empty pop yields zero.
    assign b_val = sp_ge1 ? r_top : '0;

    // The integer part of the divisor is zero when it lies strictly between
    // minus one and one.
    assign b_int_zero = (b_val[WORD_W-1:FRAC_W] == '0) ||
                        ((b_val[WORD_W-1:FRAC_W] == '1) && (b_val[FRAC_W-1:0] != '0));
    assign div_zero   = ((r_op == OP_DIV) && (b_val == '0)) ||
                        ((r_op == OP_MOD) && b_int_zero);

    // The shared unit starts from S_OPER unless the divisor check already
    // settled the token.
    assign alu_req.start = (r_state == S_OPER) && !div_zero;
    assign alu_req.op    = r_op;
    assign alu_req.a     = sp_ge2 ? r_rd : '0;
    assign alu_req.b     = b_val;

    rpn_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .o_rsp   (alu_rsp)
    );

    // Stack memory: one write port at the pointer, one registered read port
    // that always looks at the entry below the top. The read data is therefore
    // ready in S_OPER, the cycle after the token is taken.
    assign mem_we = (cmd_acc && (cmd_op == OP_PUSH) && !sp_full) ||
                    ((r_state == S_ALU) && alu_rsp.done);
    assign wr_idx  = r_sp[IDX_W-1:0];
    assign rd_idx  = IDX_W'(r_sp - SP_W'(2));
    assign wr_data = (r_state == S_IDLE) ? i_cmd.value : alu_rsp.result;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_stack[wr_idx] <= wr_data;
        end
        r_rd <= r_stack[rd_idx];
    end

    assign out_free = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // The load state refills the output register itself.
            if (o_res.ready && (r_state != S_LOAD)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (cmd_acc) begin
                        r_op    <= cmd_op;
                        // A push onto a full stack is dropped; a finish needs
                        // exactly one entry to be a good expression.
                        r_fin   <= (cmd_op == OP_FINISH);
                        r_full  <= (cmd_op == OP_PUSH) && sp_full;
                        r_empty <= 1'b0;
                        r_zdiv  <= 1'b0;
                        r_sat   <= 1'b0;
                        r_bad   <= (cmd_op == OP_FINISH) && (r_sp != SP_W'(1));
                        unique case (cmd_op)
                            OP_PUSH: begin
                                if (!sp_full) begin
                                    r_sp  <= r_sp + SP_W'(1);
                                    r_top <= i_cmd.value;
                                end
                                r_state <= S_LOAD;
                            end
                            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
                                r_state <= S_OPER;
                            end
                            OP_FINISH: begin
                                // The stack is emptied either way.
                                if (r_sp != SP_W'(1)) begin
                                    r_top <= '0;
                                end
                                r_sp    <= '0;
                                r_state <= S_LOAD;
                            end
                            default: begin
                                r_state <= S_LOAD;
                            end
                        endcase
                    end
                end
                S_OPER: begin
                    if (div_zero) begin
                        // Only the divisor is consumed; the dividend, if any,
                        // becomes the new top.
                        r_zdiv  <= 1'b1;
                        r_empty <= !sp_ge1;
                        r_sp    <= sp_ge1 ? (r_sp - SP_W'(1)) : '0;
                        r_top   <= r_rd;
                        r_state <= S_LOAD;
                    end else begin
                        r_empty <= !sp_ge2;
                        r_sp    <= sp_ge2 ? (r_sp - SP_W'(2)) : '0;
                        r_state <= S_ALU;
                    end
                end
                S_ALU: begin
                    if (alu_rsp.done) begin
                        r_top   <= alu_rsp.result;
                        r_sat   <= alu_rsp.sat;
                        r_sp    <= r_sp + SP_W'(1);
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_o_top     <= (sp_ge1 || r_fin) ? r_top : '0;
                        r_o_depth   <= DEPTH_W'(r_sp);
                        r_o_fin     <= r_fin;
                        r_o_full    <= r_full;
                        r_o_empty   <= r_empty;
                        r_o_zdiv    <= r_zdiv;
                        r_o_sat     <= r_sat;
                        r_o_bad     <= r_bad;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.top_value      = r_o_top;
    assign o_res.stack_depth    = r_o_depth;
    assign o_res.final_res      = r_o_fin;
    assign o_res.stack_full     = r_o_full;
    assign o_res.stack_empty    = r_o_empty;
    assign o_res.zero_divisor   = r_o_zdiv;
    assign o_res.saturated      = r_o_sat;
    assign o_res.bad_expression = r_o_bad;

    // The pointer never runs past the stack depth.
    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SP_W'(STACK_DEPTH))
        else $error("stack pointer beyond stack depth");

    // The shared unit only answers while the sequencer waits for it.
    a_alu_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_rsp.done |-> (r_state == S_ALU))
        else $error("arithmetic result outside the wait state");

    // A push with room grows the stack by exactly one entry.
    a_push_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd_acc && (cmd_op == OP_PUSH) && !sp_full)
        |=> (r_sp == $past(r_sp) + SP_W'(1)))
        else $error("push did not grow the stack");

    // A finish token always leaves the stack empty.
    a_fin_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd_acc && (cmd_op == OP_FINISH)) |=> (r_sp == '0))
        else $error("finish did not clear the stack");

    // A new result beat only appears out of the load state.
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_LOAD))
        else $error("result beat raised outside the load state");

endmodule

// ===== hdl/rpn_alu.sv =====
// ----------------------------------------------------------------------------
// RPN shared arithmetic unit
// Saturating add and subtract, a registered multiply with floor scaling, and
// one restoring divider that serves both divide and modulo.
// ----------------------------------------------------------------------------
module rpn_alu import rpn_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    localparam logic signed [63:0] LIM_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] LIM_LO = 64'shFFFF_FFFF_8000_0000;
    localparam logic [DIV_N_W-1:0] QUO_POS_MAX = DIV_N_W'(Q_MAX);
    localparam logic [DIV_N_W-1:0] QUO_NEG_MAX = DIV_N_W'(Q_MIN);

    typedef enum logic [1:0] {A_IDLE, A_MUL, A_DIV, A_FIN} t_state;

    t_state                    r_state;
    t_op                       r_op;
    logic signed [63:0]        r_prod;
    logic [WORD_W-1:0]         r_rem;
    logic [DIV_N_W-1:0]        r_quo;
    logic [WORD_W-1:0]         r_dvs;
    logic                      r_neg;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_done;
    logic signed [WORD_W-1:0]  r_res;
    logic                      r_sat;

    logic [WORD_W-1:0]  a_mag;
    logic [WORD_W-1:0]  b_mag;
    logic signed [63:0] sum_w;
    logic signed [63:0] diff_w;
    logic signed [63:0] prod_w;
    logic signed [63:0] prod_sh;
    logic [WORD_W:0]    rem_sh;
    logic [WORD_W:0]    trial;
    logic [WORD_W:0]    clip_sum;
    logic [WORD_W:0]    clip_diff;
    logic [WORD_W:0]    clip_prod;

    // Returns the saturation flag above the clipped 32-bit value.
    function automatic logic [WORD_W:0] clip_q(input logic signed [63:0] x);
        logic [WORD_W:0] y;
        if (x > LIM_HI) begin
            y = {1'b1, Q_MAX};
        end else if (x < LIM_LO) begin
            y = {1'b1, Q_MIN};
        end else begin
            y = {1'b0, x[WORD_W-1:0]};
        end
        return y;
    endfunction

    assign a_mag   = i_req.a[WORD_W-1] ? (~i_req.a + WORD_W'(1)) : i_req.a;
    assign b_mag   = i_req.b[WORD_W-1] ? (~i_req.b + WORD_W'(1)) : i_req.b;
    assign sum_w   = 64'(i_req.a) + 64'(i_req.b);
    assign diff_w  = 64'(i_req.a) - 64'(i_req.b);
    assign prod_w  = 64'(i_req.a) * 64'(i_req.b);
    assign prod_sh = r_prod >>> FRAC_W;

    assign clip_sum  = clip_q(sum_w);
    assign clip_diff = clip_q(diff_w);
    assign clip_prod = clip_q(prod_sh);

    // One restoring step: shift in the next dividend bit, try the subtract.
    assign rem_sh = {r_rem, r_quo[DIV_N_W-1]};
    assign trial  = rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
        end else begin
            unique case (r_state)
                A_IDLE: begin
                    // Add and subtract answer at the next edge.
                    r_done <= i_req.start &&
                              ((i_req.op == OP_ADD) || (i_req.op == OP_SUB));
                    if (i_req.start) begin
                        r_op <= i_req.op;
                        unique case (i_req.op)
                            OP_ADD: begin
                                r_res  <= clip_sum[WORD_W-1:0];
                                r_sat  <= clip_sum[WORD_W];
                            end
                            OP_SUB: begin
                                r_res  <= clip_diff[WORD_W-1:0];
                                r_sat  <= clip_diff[WORD_W];
                            end
                            OP_MUL: begin
                                r_prod  <= prod_w;
                                r_state <= A_MUL;
                            end
                            OP_DIV: begin
                                r_neg   <= i_req.a[WORD_W-1] ^ i_req.b[WORD_W-1];
                                r_quo   <= {a_mag, {FRAC_W{1'b0}}};
                                r_dvs   <= b_mag;
                                r_rem   <= '0;
                                r_cnt   <= '0;
                                r_state <= A_DIV;
                            end
                            OP_MOD: begin
                                // Both operands truncated toward zero to integers.
                                r_neg   <= i_req.a[WORD_W-1];
                                r_quo   <= DIV_N_W'(a_mag[WORD_W-1:FRAC_W]);
                                r_dvs   <= WORD_W'(b_mag[WORD_W-1:FRAC_W]);
                                r_rem   <= '0;
                                r_cnt   <= '0;
                                r_state <= A_DIV;
                            end
                            default: ;
                        endcase
                    end
                end
                A_MUL: begin
                    r_res   <= clip_prod[WORD_W-1:0];
                    r_sat   <= clip_prod[WORD_W];
                    r_done  <= 1'b1;
                    r_state <= A_IDLE;
                end
                A_DIV: begin
                    r_done <= 1'b0;
                    if (!trial[WORD_W]) begin
                        r_rem <= trial[WORD_W-1:0];
                        r_quo <= {r_quo[DIV_N_W-2:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh[WORD_W-1:0];
                        r_quo <= {r_quo[DIV_N_W-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                        r_state <= A_FIN;
                    end
                end
                A_FIN: begin
                    r_done  <= 1'b1;
                    r_state <= A_IDLE;
                    if (r_op == OP_MOD) begin
                        // The remainder keeps the sign of the dividend.
                        r_sat <= 1'b0;
                        r_res <= r_neg
                            ? (~{r_rem[FRAC_W-1:0], {FRAC_W{1'b0}}} + WORD_W'(1))
                            : {r_rem[FRAC_W-1:0], {FRAC_W{1'b0}}};
                    end else if (r_neg) begin
                        if (r_quo > QUO_NEG_MAX) begin
                            r_res <= Q_MIN;
                            r_sat <= 1'b1;
                        end else begin
                            r_res <= ~r_quo[WORD_W-1:0] + WORD_W'(1);
                            r_sat <= 1'b0;
                        end
                    end else begin
                        if (r_quo > QUO_POS_MAX) begin
                            r_res <= Q_MAX;
                            r_sat <= 1'b1;
                        end else begin
                            r_res <= r_quo[WORD_W-1:0];
                            r_sat <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_done  <= 1'b0;
                    r_state <= A_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_res;
    assign o_rsp.sat    = r_sat;

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// RPN stack calculator testbench
// Sends token beats into the calculator and checks every result beat against
// a Q15.16 stack model kept in the bench. It starts with a short list of
// corner tokens, then runs random expressions, broken token runs and
// stack-filling runs. Random idle bursts, a long result hold-off and a
// full drain of the sender check the handshakes.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rpn_pkg::*;

    // The one opcode that the block ignores.
    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

    // Approximate number of tokens that do real work in the random part.
    localparam int TOKEN_TARGET = 1900;
    // The final stretch of tokens runs with both sides always ready.
    localparam int CALM_TAIL    = 200;
    // Length of the single long hold-off on the result channel, in cycles.
    localparam int RX_LONG_HOLD = 250;
    // Cycles allowed after the last result before the run ends.
    localparam int DRAIN_CYCLES = 60;

    // Saturation bounds of Q15.16, widened for 64-bit intermediate results.
    localparam longint Q_HI = 64'sd2147483647;
    localparam longint Q_LO = -64'sd2147483648;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [WORD_W-1:0] value;
    } t_token;

    typedef struct packed {
        logic signed [WORD_W-1:0] top_value;
        logic [DEPTH_W-1:0]       stack_depth;
        logic                     final_res;
        logic                     stack_full;
        logic                     stack_empty;
        logic                     zero_divisor;
        logic                     saturated;
        logic                     bad_expression;
    } t_calc_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rpn_cmd_if cmd_if ();
    rpn_res_if res_if ();

    rpn_stack_calculator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    always #5 i_clk = ~i_clk;

    // Tokens waiting to be driven, and results that the model expects back,
    // oldest first.
    t_token       token_q[$];
    t_calc_result outcome_q[$];

    int queued_cnt   = 0;  // every token put into token_q
    int accepted_cnt = 0;  // every token beat taken by the block
    int work_cnt     = 0;  // queued tokens other than the ignored opcode
    int fail_cnt     = 0;

    bit idle_on     = 1'b0;  // random idle bursts allowed on both sides
    bit rx_long_req = 1'b0;  // asks the result sink for one long hold-off
    int tx_gap      = 0;
    int rx_hold     = 0;
    bit cmd_taken   = 1'b0;  // the token beat on the bus went in at the last edge

    // ------------------------------------------------------------------------
    // Stack model. It keeps its own copy of the stack and the stack pointer
    // and works out the one result beat that each accepted token produces.
    // ------------------------------------------------------------------------
    logic signed [WORD_W-1:0] calc_stack [RPN_STACK_DEPTH];
    int calc_depth = 0;
    bit f_empty, f_full, f_sat;

    // A pop from an empty stack gives zero and raises the empty flag.
    function automatic logic signed [WORD_W-1:0] calc_pop();
        if (calc_depth > 0) begin
            calc_depth--;
            return calc_stack[calc_depth];
        end
        f_empty = 1'b1;
        return '0;
    endfunction

    // A push on a full stack is dropped and raises the full flag.
    function automatic void calc_push(logic signed [WORD_W-1:0] v);
        if (calc_depth < RPN_STACK_DEPTH) begin
            calc_stack[calc_depth] = v;
            calc_depth++;
        end else begin
            f_full = 1'b1;
        end
    endfunction

    function automatic logic signed [WORD_W-1:0] calc_clip(longint x);
        if (x > Q_HI) begin
            f_sat = 1'b1;
            return Q_MAX;
        end
        if (x < Q_LO) begin
            f_sat = 1'b1;
            return Q_MIN;
        end
        return x[WORD_W-1:0];
    endfunction

    function automatic t_calc_result calc_step(t_token t);
        t_calc_result r;
        logic signed [WORD_W-1:0] a, b;
        longint p;
        int ia, ib;
        r = '0;
        f_empty = 1'b0;
        f_full  = 1'b0;
        f_sat   = 1'b0;
        // The first pop is always the right operand, the second the left one.
        case (t.op)
            OP_PUSH: calc_push(t.value);
            OP_ADD: begin
                b = calc_pop();
                a = calc_pop();
                calc_push(calc_clip(longint'(a) + longint'(b)));
            end
            OP_SUB: begin
                b = calc_pop();
                a = calc_pop();
                calc_push(calc_clip(longint'(a) - longint'(b)));
            end
            OP_MUL: begin
                // The arithmetic shift of the full product rounds toward
                // minus infinity.
                b = calc_pop();
                a = calc_pop();
                p = longint'(a) * longint'(b);
                calc_push(calc_clip(p >>> FRAC_W));
            end
            OP_DIV: begin
                // A zero divisor is consumed and the dividend stays put.
                b = calc_pop();
                if (b == 0) begin
                    r.zero_divisor = 1'b1;
                end else begin
                    a = calc_pop();
                    p = (longint'(a) <<< FRAC_W) / longint'(b);
                    calc_push(calc_clip(p));
                end
            end
            OP_MOD: begin
                // Both operands lose their fractions first; a divisor with
                // no integer part counts as zero.
                b = calc_pop();
                ib = int'(b) / (1 << FRAC_W);
                if (ib == 0) begin
                    r.zero_divisor = 1'b1;
                end else begin
                    a = calc_pop();
                    ia = int'(a) / (1 << FRAC_W);
                    calc_push((ia % ib) * (1 << FRAC_W));
                end
            end
            OP_FINISH: begin
                r.final_res = 1'b1;
                if (calc_depth == 1) begin
                    r.top_value = calc_stack[0];
                end else begin
                    r.bad_expression = 1'b1;
                end
                calc_depth = 0;
            end
            default: ;
        endcase
        if (!r.final_res && calc_depth > 0) begin
            r.top_value = calc_stack[calc_depth-1];
        end
        r.stack_depth  = DEPTH_W'(calc_depth);
        r.stack_full   = f_full;
        r.stack_empty  = f_empty;
        r.saturated    = f_sat;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    task automatic add_token(logic [OP_W-1:0] op, logic [WORD_W-1:0] value);
        t_token t;
        t.op    = op;
        t.value = value;
        token_q.push_back(t);
        queued_cnt++;
        if (op != OP_UNUSED) begin
            work_cnt++;
        end
    endtask

    // Numbers lean toward small magnitudes so that division and modulo mostly
    // stay in range, with extremes, zero and pure fractions mixed in.
    function automatic logic [WORD_W-1:0] rand_value();
        int v;
        case ($urandom_range(0, 9))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return '0;
            3: begin
                v = int'($urandom_range(1, 65535));
                return ($urandom_range(0, 1) != 0) ? v : -v;
            end
            4, 5: return $urandom;
            default: begin
                v = (int'($urandom_range(0, 40)) - 20) * (1 << FRAC_W);
                if ($urandom_range(0, 1) != 0) begin
                    v = v + int'($urandom_range(0, 65535));
                end
                return v;
            end
        endcase
    endfunction

    // A well-formed expression: it never pops an empty stack and ends at
    // depth one, so the finish token reports a value. An ignored opcode is
    // slipped in now and then.
    task automatic queue_expression();
        int leaves, pushed, depth;
        leaves = $urandom_range(1, 8);
        pushed = 0;
        depth  = 0;
        while (pushed < leaves || depth > 1) begin
            if ($urandom_range(0, 30) == 0) begin
                add_token(OP_UNUSED, $urandom);
            end
            if (depth >= 2 && (pushed == leaves || $urandom_range(0, 2) == 0)) begin
                add_token(OP_W'($urandom_range(OP_ADD, OP_MOD)), $urandom);
                depth--;
            end else begin
                add_token(OP_PUSH, rand_value());
                pushed++;
                depth++;
            end
        end
        add_token(OP_FINISH, $urandom);
    endtask

    // Random tokens with no regard for depth: empty pops, bad finishes.
    task automatic queue_noise();
        int len;
        len = $urandom_range(1, 8);
        repeat (len) begin
            add_token(OP_W'($urandom_range(OP_PUSH, OP_UNUSED)), rand_value());
        end
        if ($urandom_range(0, 1) != 0) begin
            add_token(OP_FINISH, $urandom);
        end
    endtask

    // Pushes past the top of the stack, works on a full stack, then finishes
    // with a bad depth.
    task automatic queue_fill();
        repeat (RPN_STACK_DEPTH + $urandom_range(1, 3)) begin
            add_token(OP_PUSH, rand_value());
        end
        repeat ($urandom_range(2, 5)) begin
            add_token(OP_W'($urandom_range(OP_ADD, OP_MOD)), $urandom);
        end
        add_token(OP_PUSH, rand_value());
        add_token(OP_FINISH, $urandom);
    endtask

    // ------------------------------------------------------------------------
    // Token driver. A new beat is put on the bus at the falling edge once the
    // previous one has gone in; random idle bursts are inserted while idling
    // is allowed.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : token_driver
        t_token nxt;
        logic   drive;
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else if (!cmd_if.valid || cmd_taken) begin
            drive = 1'b0;
            if (tx_gap > 0) begin
                tx_gap--;
            end else if (idle_on && $urandom_range(0, 6) == 0) begin
                tx_gap = $urandom_range(0, 11);
            end else if (token_q.size() > 0) begin
                nxt = token_q.pop_front();
                cmd_if.op    <= nxt.op;
                cmd_if.value <= nxt.value;
                drive = 1'b1;
            end
            cmd_if.valid <= drive;
        end
    end

    // ------------------------------------------------------------------------
    // Result sink. Ready drops for random bursts while idling is allowed, and
    // once for a long stretch on request, so that the block backs up and
    // stops taking tokens.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : result_sink
        if (rx_hold > 0) begin
            rx_hold--;
            res_if.ready <= 1'b0;
        end else if (rx_long_req) begin
            rx_long_req = 1'b0;
            rx_hold = RX_LONG_HOLD - 1;
            res_if.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 6) == 0) begin
            rx_hold = $urandom_range(0, 11);
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    task automatic check_field(string name, logic signed [WORD_W-1:0] want,
                               logic signed [WORD_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_cnt++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Beat monitor. At each rising edge an accepted token beat updates the
    // model and queues its expected result; an accepted result beat is
    // checked field by field against the oldest expectation.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : beat_monitor
        t_token       tok;
        t_calc_result got, want;
        if (!i_rst_n) begin
            cmd_taken <= 1'b0;
        end else begin
            cmd_taken <= cmd_if.valid && cmd_if.ready;
            if (cmd_if.valid && cmd_if.ready) begin
                tok.op    = cmd_if.op;
                tok.value = cmd_if.value;
                outcome_q.push_back(calc_step(tok));
                accepted_cnt++;
            end
            if (res_if.valid && res_if.ready) begin
                if (outcome_q.size() == 0) begin
                    $error("result beat arrived with no token outstanding");
                    fail_cnt++;
                end else begin
                    want = outcome_q.pop_front();
                    got.top_value      = res_if.top_value;
                    got.stack_depth    = res_if.stack_depth;
                    got.final_res      = res_if.final_res;
                    got.stack_full     = res_if.stack_full;
                    got.stack_empty    = res_if.stack_empty;
                    got.zero_divisor   = res_if.zero_divisor;
                    got.saturated      = res_if.saturated;
                    got.bad_expression = res_if.bad_expression;
                    check_field("top_value", want.top_value, got.top_value);
                    check_field("stack_depth", WORD_W'(want.stack_depth),
                                WORD_W'(got.stack_depth));
                    check_field("final_res", WORD_W'(want.final_res),
                                WORD_W'(got.final_res));
                    check_field("stack_full", WORD_W'(want.stack_full),
                                WORD_W'(got.stack_full));
                    check_field("stack_empty", WORD_W'(want.stack_empty),
                                WORD_W'(got.stack_empty));
                    check_field("zero_divisor", WORD_W'(want.zero_divisor),
                                WORD_W'(got.zero_divisor));
                    check_field("saturated", WORD_W'(want.saturated),
                                WORD_W'(got.saturated));
                    check_field("bad_expression", WORD_W'(want.bad_expression),
                                WORD_W'(got.bad_expression));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int seq_cnt;
        int batch_end;
        bit long_done;
        cmd_if.valid = 1'b0;
        cmd_if.op    = '0;
        cmd_if.value = '0;
        res_if.ready = 1'b0;
        i_rst_n      = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Corner tokens, run with no idling.
        add_token(OP_FINISH, 32'h0000_0000);  // finish on an empty stack
        add_token(OP_ADD,    32'h0000_0000);  // both pops find the stack empty
        add_token(OP_FINISH, 32'hFFFF_FFFF);  // a single zero is a good result
        add_token(OP_PUSH,   32'h7FFF_FFFF);
        add_token(OP_PUSH,   32'h0000_0001);
        add_token(OP_ADD,    32'h0000_0000);  // sum clips at the top
        add_token(OP_PUSH,   32'h8000_0000);
        add_token(OP_SUB,    32'h0000_0000);  // largest minus smallest clips
        add_token(OP_PUSH,   32'h0003_0000);  // 3.0
        add_token(OP_PUSH,   32'hFFFD_8000);  // -2.5
        add_token(OP_MUL,    32'h0000_0000);  // -7.5
        add_token(OP_MUL,    32'h0000_0000);  // product clips at the bottom
        add_token(OP_PUSH,   32'hFFFF_FFFF);
        add_token(OP_DIV,    32'h0000_0000);  // quotient clips at the top
        add_token(OP_PUSH,   32'h0000_0000);
        add_token(OP_DIV,    32'h0000_0000);  // zero divisor, dividend kept
        add_token(OP_PUSH,   32'h0000_FFFF);
        add_token(OP_MOD,    32'h0000_0000);  // divisor below one counts as zero
        add_token(OP_PUSH,   32'hFFFB_0000);  // -5.0
        add_token(OP_MOD,    32'h0000_0000);
        add_token(OP_UNUSED, 32'h1234_5678);  // ignored opcode
        add_token(OP_PUSH,   32'h0001_8000);  // 1.5
        add_token(OP_FINISH, 32'h0000_0000);  // two entries left: bad depth
        add_token(OP_MOD,    32'h0000_0000);  // empty pop gives a zero divisor
        add_token(OP_FINISH, 32'h0000_0000);

        // The sender holds back until every outstanding result is in.
        while (accepted_cnt < queued_cnt || outcome_q.size() > 0) begin
            @(negedge i_clk);
        end

        // Random part, in batches of about 40 tokens. Each batch either has
        // idling on both sides or none at all; the tail has none.
        seq_cnt   = 0;
        long_done = 1'b0;
        work_cnt  = 0;
        while (work_cnt < TOKEN_TARGET) begin
            idle_on   = (work_cnt < TOKEN_TARGET - CALM_TAIL) &&
                        ($urandom_range(0, 3) != 0);
            batch_end = work_cnt + 40;
            while (work_cnt < batch_end) begin
                seq_cnt++;
                if (seq_cnt % 80 == 30) begin
                    queue_fill();
                end else if ($urandom_range(0, 9) < 7) begin
                    queue_expression();
                end else begin
                    queue_noise();
                end
            end
            // Midway, the sink stops taking results for a long stretch while
            // this batch is still being offered.
            if (!long_done && work_cnt > TOKEN_TARGET / 2) begin
                rx_long_req = 1'b1;
                long_done   = 1'b1;
            end
            while (queued_cnt - accepted_cnt > 2) begin
                @(negedge i_clk);
            end
        end
        idle_on = 1'b0;

        while (accepted_cnt < queued_cnt || outcome_q.size() > 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_cnt == 0) begin
            $display("rpn_stack_calculator verification clean");
        end else begin
            $display("rpn_stack_calculator verification failed");
        end
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial begin : watchdog
        #8_000_000;
        $display("rpn_stack_calculator verification failed");
        $finish;
    end

endmodule
